>>> rtl/core/gmm_pkg.sv
package gmm_pkg;

	// fixed point format and table size
	localparam int FRAC_BITS = 16;
	localparam int TBL_N     = 256;

	// theta squared and its square root
	localparam int TS_W   = 33;
	localparam int RAD_W  = TS_W + FRAC_BITS;
	localparam int TH_W   = (RAD_W + 1) / 2;
	localparam int RAD_PW = 2 * TH_W;

	// mean difference and alpha
	localparam int DM_W  = 33;
	localparam int Q_W   = FRAC_BITS + 4;
	localparam int AL_W  = FRAC_BITS + 5;
	localparam int FSH   = FRAC_BITS + 4;
	localparam int IDX_W = $clog2(TBL_N + 1);
	localparam int POS_W = AL_W + IDX_W;

	// probabilities in q1.30
	localparam int T_W = 31;
	localparam logic [T_W-1:0] ONE_Q30 = {1'b1, 30'd0};
	localparam logic [AL_W-1:0] LIM = AL_W'(8) << FRAC_BITS;

	// variance datapath widths
	localparam int PRD_W = T_W + FSH + 1;
	localparam int A2_W  = 2 * (AL_W - 1) - FRAC_BITS;
	localparam int T1_W  = A2_W + T_W - FRAC_BITS;
	localparam int T2P_W = AL_W + 32;
	localparam int T2_W  = T2P_W - FRAC_BITS;
	localparam int B_W   = T1_W + 2;
	localparam int BL    = 18;
	localparam int BH_W  = B_W - BL;
	localparam int PR_W  = TS_W + B_W;
	localparam int MAG_W = PR_W - 30;
	localparam int VT_W  = MAG_W + 2;

	localparam longint unsigned INV_SQRT_2PI_Q30 = 64'd428361012;

	// table build divisors
	localparam longint unsigned PDF_DIV = 64'd2 * TBL_N * TBL_N;
	localparam longint unsigned CDF_DIV = 64'd3 * TBL_N;
	localparam longint unsigned CDF_RND = CDF_DIV / 2;

	typedef logic [T_W-1:0] tab_t [0:TBL_N];

	// operand set that travels with the square root and the divider
	typedef struct packed {
		logic signed [31:0] ma;
		logic signed [31:0] mb;
		logic [30:0]        va;
		logic [30:0]        vb;
		logic [TS_W-1:0]    ts;
		logic               d_neg;
		logic [DM_W-1:0]    dmag;
	} side_t;

	// unsigned long division for the table build
	function automatic longint unsigned udiv64(input longint unsigned n,
			input longint unsigned d);
		longint unsigned q;
		longint unsigned r;
		q = 64'd0;
		r = 64'd0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[62:0], n[i]};
			if (r >= d) begin
				r    = r - d;
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// exp(-r) for r in [0, 1.0], q30, by series
	function automatic longint unsigned exp_frac(input longint unsigned r);
		longint          sum;
		longint unsigned term;
		sum  = longint'(1) << 30;
		term = 64'd1 << 30;
		for (int k = 1; k <= 16; k++) begin
			term = udiv64((term * r) >> 30, 64'(k));
			if (k[0]) begin
				sum = sum - $signed(term);
			end else begin
				sum = sum + $signed(term);
			end
		end
		return (sum < 0) ? 64'd0 : $unsigned(sum);
	endfunction

	// exp(-y), y in q30
	function automatic longint unsigned exp_neg(input longint unsigned y);
		longint unsigned n;
		longint unsigned v;
		longint unsigned e1;
		n  = y >> 30;
		v  = exp_frac(y & ((64'd1 << 30) - 64'd1));
		e1 = exp_frac(64'd1 << 30);
		for (longint unsigned i = 0; i < n; i++) begin
			v = (v * e1) >> 30;
		end
		return v;
	endfunction

	// normal density at m / TBL_N, q30
	function automatic longint unsigned pdf_at(input longint m);
		longint unsigned mm;
		longint unsigned y;
		mm = $unsigned((m < 0) ? -m : m);
		y  = udiv64((mm * mm) << 30, PDF_DIV);
		return (exp_neg(y) * INV_SQRT_2PI_Q30) >> 30;
	endfunction

	function automatic tab_t build_pdf();
		tab_t tb;
		for (int k = 0; k < TBL_N; k++) begin
			tb[k] = T_W'(pdf_at(longint'(16 * k - 8 * TBL_N)));
		end
		tb[TBL_N] = T_W'(pdf_at(longint'(8 * TBL_N)));
		return tb;
	endfunction

	// running simpson integral of the density, capped at one
	function automatic tab_t build_cdf();
		tab_t            tb;
		longint unsigned acc;
		longint unsigned ws;
		longint unsigned w;
		longint unsigned c;
		acc   = 64'd0;
		tb[0] = '0;
		for (int k = 0; k < TBL_N; k++) begin
			ws = 64'd0;
			for (int i = 0; i <= 8; i++) begin
				w  = (i == 0 || i == 8) ? 64'd1 : (i[0] ? 64'd4 : 64'd2);
				ws = ws + w * pdf_at(longint'(16 * k + 2 * i - 8 * TBL_N));
			end
			acc = acc + ws;
			c = udiv64(64'd2 * acc + CDF_RND, CDF_DIV);
			tb[k+1] = (c > (64'd1 << 30)) ? ONE_Q30 : T_W'(c);
		end
		tb[TBL_N] = ONE_Q30;
		return tb;
	endfunction

	localparam tab_t CDF_TAB = build_cdf();
	localparam tab_t PDF_TAB = build_pdf();

endpackage

>>> rtl/core/gaussian_max_moments.sv
// Clark moments of the max of two jointly gaussian variables.
// Command channel: drive mean_a, mean_b, var_a, var_b, cov_ab with start high;
// the item is taken at that edge whenever busy is low. busy never rises, so a
// new item may be issued on every clock.
// Result channel: done pulses for one cycle with mean_z, var_z and var_negative
// valid in that same cycle. The receiver cannot hold results off and the block
// needs no backpressure: no stage of the pipeline ever stalls.
// The pipeline holds an operand setup stage, one stage per square root bit,
// one per quotient bit plus an overflow check, then eleven stages of table
// lookup, interpolation and multiply-add. Throughput is one item per cycle.
// Config: min_variance is written over cfg_valid/cfg_data (cfg_ready is always
// high); the user must write it only when no items are in flight; the block does not enforce this.
// Reset clears the pipeline valid bits and sets min_variance to 1.
module gaussian_max_moments (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] mean_a,
	input  logic signed [31:0] mean_b,
	input  logic [30:0]        var_a,
	input  logic [30:0]        var_b,
	input  logic signed [31:0] cov_ab,
	output logic               done,
	output logic signed [31:0] mean_z,
	output logic [30:0]        var_z,
	output logic               var_negative,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [30:0]        cfg_data
);
	import gmm_pkg::*;

	localparam int LAT = TH_W + Q_W + 13;

	logic [30:0] min_var_q;

	// stage 1 signals
	logic signed [34:0] ts_raw;
	logic [30:0]        mv;
	logic signed [32:0] dd;
	side_t              side_n;
	logic               vld_s1;
	side_t              side_s1;

	// square root and divider
	logic               sq_vld;
	side_t              sq_side;
	logic [TH_W-1:0]    sq_theta;
	logic               dv_vld;
	side_t              dv_side;
	logic [TH_W-1:0]    dv_theta;
	logic [Q_W-1:0]     dv_amag;
	logic               dv_ovf;

	// alpha
	logic                   sat_hi;
	logic                   sat_lo;
	logic [AL_W-1:0]        amag_x;
	logic signed [AL_W-1:0] al_n;
	logic                   vld_s2;
	side_t                  side_s2;
	logic [TH_W-1:0]        theta_s2;
	logic signed [AL_W-1:0] al_s2;
	logic [AL_W-1:0]        u_s2;
	logic                   sat_hi_s2;
	logic                   sat_lo_s2;

	// table read
	logic [POS_W-1:0]       pos;
	logic [POS_W-FSH-1:0]   idx_w;
	logic [IDX_W-1:0]       idx;
	logic [FSH-1:0]         fr;
	logic                   vld_s3;
	side_t                  side_s3;
	logic [TH_W-1:0]        theta_s3;
	logic signed [AL_W-1:0] al_s3;
	logic                   sat_hi_s3;
	logic                   sat_lo_s3;
	logic [T_W-1:0]         c0_s3;
	logic [T_W-1:0]         c1_s3;
	logic [T_W-1:0]         p0_s3;
	logic [T_W-1:0]         p1_s3;
	logic [FSH:0]           w0_s3;
	logic [FSH-1:0]         w1_s3;

	// interpolation products
	logic                   vld_s4;
	side_t                  side_s4;
	logic [TH_W-1:0]        theta_s4;
	logic signed [AL_W-1:0] al_s4;
	logic                   sat_hi_s4;
	logic                   sat_lo_s4;
	logic [PRD_W-1:0]       pc0_s4;
	logic [PRD_W-1:0]       pc1_s4;
	logic [PRD_W-1:0]       pp0_s4;
	logic [PRD_W-1:0]       pp1_s4;

	// t and p
	logic [PRD_W:0]         csum;
	logic [PRD_W:0]         psum;
	logic                   vld_s5;
	side_t                  side_s5;
	logic [TH_W-1:0]        theta_s5;
	logic signed [AL_W-1:0] al_s5;
	logic [T_W-1:0]         t_s5;
	logic [T_W-1:0]         p_s5;

	// moment products
	logic [T_W-1:0]         omt;
	logic signed [32:0]     m2t;
	logic [AL_W-2:0]        almag;
	logic                   vld_s6;
	logic [TS_W-1:0]        ts_s6;
	logic signed [AL_W-1:0] al_s6;
	logic signed [63:0]     mat_s6;
	logic signed [63:0]     mbt_s6;
	logic [TH_W+T_W-1:0]    thp_s6;
	logic [61:0]            vat_s6;
	logic [61:0]            vbt_s6;
	logic [61:0]            ttp_s6;
	logic [2*AL_W-3:0]      alsq_s6;
	logic signed [63:0]     psp_s6;
	logic [61:0]            ppp_s6;

	// sums and rescaling
	logic [62:0]            vsum;
	logic signed [63:0]     psb;
	logic                   vld_s7;
	logic [TS_W-1:0]        ts_s7;
	logic signed [AL_W-1:0] al_s7;
	logic signed [63:0]     macc_s7;
	logic [30:0]            v0_s7;
	logic [T_W-1:0]         tt_s7;
	logic [A2_W-1:0]        a2_s7;
	logic signed [31:0]     ps_s7;
	logic [T_W-1:0]         pp_s7;

	// mean saturation and variance term products
	logic signed [63:0]     mzb;
	logic signed [63:0]     mzw;
	logic                   vld_s8;
	logic [TS_W-1:0]        ts_s8;
	logic [30:0]            v0_s8;
	logic [T_W-1:0]         pp_s8;
	logic signed [31:0]     mz_s8;
	logic [A2_W+T_W-1:0]    tt1p_s8;
	logic signed [T2P_W-1:0] t2p_s8;

	// bracket term
	logic signed [T2P_W-1:0] t2b;
	logic signed [T2_W-1:0]  t2;
	logic                    vld_s9;
	logic [TS_W-1:0]         ts_s9;
	logic [30:0]             v0_s9;
	logic signed [31:0]      mz_s9;
	logic signed [B_W-1:0]   b_s9;

	// theta squared times bracket, split product
	logic [B_W-1:0]          bmag;
	logic                    vld_s10;
	logic [30:0]             v0_s10;
	logic signed [31:0]      mz_s10;
	logic                    bneg_s10;
	logic [TS_W+BH_W-1:0]    phi_s10;
	logic [TS_W+BL-1:0]      plo_s10;

	logic [PR_W-1:0]         prsum;
	logic                    vld_s11;
	logic [30:0]             v0_s11;
	logic signed [31:0]      mz_s11;
	logic                    bneg_s11;
	logic [MAG_W-1:0]        mag_s11;

	// final variance
	logic signed [VT_W-1:0]  vt;
	logic                    vld_s12;
	logic signed [31:0]      mz_s12;
	logic [30:0]             vz_s12;
	logic                    vneg_s12;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_var_q <= 31'd1;
		end else if (cfg_valid && cfg_ready) begin
			min_var_q <= cfg_data;
		end
	end

	// valid bits for the stages in this module
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
		end else begin
			vld_s1  <= start && !busy;
			vld_s2  <= dv_vld;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
			vld_s12 <= vld_s11;
		end
	end

	// stage 1: clamped theta squared and mean difference
	always_comb begin
		ts_raw = $signed({4'b0, var_a}) + $signed({4'b0, var_b})
			- $signed({{2{cov_ab[31]}}, cov_ab, 1'b0});
		mv = (min_var_q == '0) ? 31'd1 : min_var_q;
		dd = $signed({mean_a[31], mean_a}) - $signed({mean_b[31], mean_b});
		side_n.ma    = mean_a;
		side_n.mb    = mean_b;
		side_n.va    = var_a;
		side_n.vb    = var_b;
		side_n.ts    = (ts_raw < $signed({4'b0, mv})) ? TS_W'(mv) : ts_raw[TS_W-1:0];
		side_n.d_neg = dd[32];
		side_n.dmag  = dd[32] ? DM_W'(-dd) : DM_W'(dd);
	end

	always_ff @(posedge clk) begin
		side_s1 <= side_n;
	end

	gmm_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s1),
		.in_side   (side_s1),
		.out_valid (sq_vld),
		.out_side  (sq_side),
		.out_theta (sq_theta)
	);

	gmm_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sq_vld),
		.in_side   (sq_side),
		.in_theta  (sq_theta),
		.out_valid (dv_vld),
		.out_side  (dv_side),
		.out_theta (dv_theta),
		.out_amag  (dv_amag),
		.out_ovf   (dv_ovf)
	);

	// stage 2: signed alpha with saturation at the table ends
	always_comb begin
		amag_x = AL_W'(dv_amag);
		sat_hi = !dv_side.d_neg && (dv_ovf || amag_x >= LIM);
		sat_lo = dv_side.d_neg && (dv_ovf || amag_x > LIM);
		priority if (sat_hi) begin
			al_n = $signed(LIM);
		end else if (sat_lo) begin
			al_n = -$signed(LIM);
		end else if (dv_side.d_neg) begin
			al_n = -$signed(amag_x);
		end else begin
			al_n = $signed(amag_x);
		end
	end

	always_ff @(posedge clk) begin
		side_s2   <= dv_side;
		theta_s2  <= dv_theta;
		al_s2     <= al_n;
		u_s2      <= $unsigned(al_n) + LIM;
		sat_hi_s2 <= sat_hi;
		sat_lo_s2 <= sat_lo;
	end

	// stage 3: table index and fraction, table read
	always_comb begin
		pos   = POS_W'(u_s2) * POS_W'(TBL_N);
		idx_w = pos[POS_W-1:FSH];
		if (idx_w > (POS_W-FSH)'(TBL_N - 1)) begin
			idx = IDX_W'(TBL_N - 1);
			fr  = '1;
		end else begin
			idx = IDX_W'(idx_w);
			fr  = pos[FSH-1:0];
		end
	end

	always_ff @(posedge clk) begin
		side_s3   <= side_s2;
		theta_s3  <= theta_s2;
		al_s3     <= al_s2;
		sat_hi_s3 <= sat_hi_s2;
		sat_lo_s3 <= sat_lo_s2;
		c0_s3     <= CDF_TAB[idx];
		c1_s3     <= CDF_TAB[idx + IDX_W'(1)];
		p0_s3     <= PDF_TAB[idx];
		p1_s3     <= PDF_TAB[idx + IDX_W'(1)];
		w0_s3     <= {1'b1, {FSH{1'b0}}} - {1'b0, fr};
		w1_s3     <= fr;
	end

	// stage 4: interpolation products
	always_ff @(posedge clk) begin
		side_s4   <= side_s3;
		theta_s4  <= theta_s3;
		al_s4     <= al_s3;
		sat_hi_s4 <= sat_hi_s3;
		sat_lo_s4 <= sat_lo_s3;
		pc0_s4    <= c0_s3 * w0_s3;
		pc1_s4    <= c1_s3 * w1_s3;
		pp0_s4    <= p0_s3 * w0_s3;
		pp1_s4    <= p1_s3 * w1_s3;
	end

	// stage 5: interpolated cdf and pdf
	assign csum = {1'b0, pc0_s4} + {1'b0, pc1_s4};
	assign psum = {1'b0, pp0_s4} + {1'b0, pp1_s4};

	always_ff @(posedge clk) begin
		side_s5  <= side_s4;
		theta_s5 <= theta_s4;
		al_s5    <= al_s4;
		priority if (sat_hi_s4) begin
			t_s5 <= ONE_Q30;
			p_s5 <= '0;
		end else if (sat_lo_s4) begin
			t_s5 <= '0;
			p_s5 <= '0;
		end else begin
			t_s5 <= csum[FSH +: T_W];
			p_s5 <= psum[FSH +: T_W];
		end
	end

	// stage 6: products for mean and variance
	always_comb begin
		omt   = ONE_Q30 - t_s5;
		m2t   = $signed({2'b0, ONE_Q30}) - $signed({1'b0, t_s5, 1'b0});
		almag = (AL_W-1)'(al_s5[AL_W-1] ? -al_s5 : al_s5);
	end

	always_ff @(posedge clk) begin
		ts_s6   <= side_s5.ts;
		al_s6   <= al_s5;
		mat_s6  <= side_s5.ma * $signed({1'b0, t_s5});
		mbt_s6  <= side_s5.mb * $signed({1'b0, omt});
		thp_s6  <= theta_s5 * p_s5;
		vat_s6  <= side_s5.va * t_s5;
		vbt_s6  <= side_s5.vb * omt;
		ttp_s6  <= t_s5 * omt;
		alsq_s6 <= almag * almag;
		psp_s6  <= $signed({1'b0, p_s5}) * m2t;
		ppp_s6  <= p_s5 * p_s5;
	end

	// stage 7: mean accumulate, rescale variance terms
	always_comb begin
		vsum = {1'b0, vat_s6} + {1'b0, vbt_s6};
		psb  = psp_s6 + (psp_s6[63] ? 64'sd1073741823 : 64'sd0);
	end

	always_ff @(posedge clk) begin
		ts_s7   <= ts_s6;
		al_s7   <= al_s6;
		macc_s7 <= mat_s6 + mbt_s6 + $signed(64'(thp_s6));
		v0_s7   <= vsum[30 +: 31];
		tt_s7   <= ttp_s6[30 +: T_W];
		a2_s7   <= alsq_s6[FRAC_BITS +: A2_W];
		ps_s7   <= 32'(psb >>> 30);
		pp_s7   <= ppp_s6[30 +: T_W];
	end

	// stage 8: mean rounding toward zero and saturation
	always_comb begin
		mzb = macc_s7 + (macc_s7[63] ? 64'sd1073741823 : 64'sd0);
		mzw = mzb >>> 30;
	end

	always_ff @(posedge clk) begin
		ts_s8   <= ts_s7;
		v0_s8   <= v0_s7;
		pp_s8   <= pp_s7;
		tt1p_s8 <= a2_s7 * tt_s7;
		t2p_s8  <= al_s7 * ps_s7;
		priority if (mzw > 64'sd2147483647) begin
			mz_s8 <= 32'sh7fffffff;
		end else if (mzw < -64'sd2147483648) begin
			mz_s8 <= 32'sh80000000;
		end else begin
			mz_s8 <= mzw[31:0];
		end
	end

	// stage 9: bracket of the variance expansion
	always_comb begin
		t2b = t2p_s8 + (t2p_s8[T2P_W-1] ? T2P_W'((1 << FRAC_BITS) - 1) : '0);
		t2  = T2_W'(t2b >>> FRAC_BITS);
	end

	always_ff @(posedge clk) begin
		ts_s9 <= ts_s8;
		v0_s9 <= v0_s8;
		mz_s9 <= mz_s8;
		b_s9  <= $signed(B_W'(tt1p_s8[FRAC_BITS +: T1_W])) + B_W'(t2)
			- $signed(B_W'(pp_s8));
	end

	// stage 10: magnitude split into two partial products
	assign bmag = b_s9[B_W-1] ? $unsigned(-b_s9) : $unsigned(b_s9);

	always_ff @(posedge clk) begin
		v0_s10   <= v0_s9;
		mz_s10   <= mz_s9;
		bneg_s10 <= b_s9[B_W-1];
		phi_s10  <= ts_s9 * bmag[B_W-1:BL];
		plo_s10  <= ts_s9 * bmag[BL-1:0];
	end

	// stage 11: recombine and drop 30 fraction bits
	assign prsum = (PR_W'(phi_s10) << BL) + PR_W'(plo_s10);

	always_ff @(posedge clk) begin
		v0_s11   <= v0_s10;
		mz_s11   <= mz_s10;
		bneg_s11 <= bneg_s10;
		mag_s11  <= prsum[30 +: MAG_W];
	end

	// stage 12: final variance, clamp and flag
	assign vt = bneg_s11 ? ($signed(VT_W'(v0_s11)) - $signed(VT_W'(mag_s11)))
		: ($signed(VT_W'(v0_s11)) + $signed(VT_W'(mag_s11)));

	always_ff @(posedge clk) begin
		mz_s12 <= mz_s11;
		priority if (vt < 0) begin
			vz_s12   <= '0;
			vneg_s12 <= 1'b1;
		end else if (vt > $signed(VT_W'(31'h7fffffff))) begin
			vz_s12   <= 31'h7fffffff;
			vneg_s12 <= 1'b0;
		end else begin
			vz_s12   <= vt[30:0];
			vneg_s12 <= 1'b0;
		end
	end

	assign done         = vld_s12;
	assign mean_z       = mz_s12;
	assign var_z        = vz_s12;
	assign var_negative = vneg_s12;

	// checks
	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("result without a command LAT cycles earlier");

	a_sat_excl: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> !(sat_hi_s2 && sat_lo_s2))
		else $error("alpha saturated at both ends");

	a_t_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s5 |-> t_s5 <= ONE_Q30)
		else $error("interpolated cdf above one");

	a_neg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && var_negative) |-> var_z == '0)
		else $error("negative variance not cleared");

endmodule

>>> rtl/core/gmm_sqrt.sv
module gmm_sqrt (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  gmm_pkg::side_t            in_side,
	output logic                      out_valid,
	output gmm_pkg::side_t            out_side,
	output logic [gmm_pkg::TH_W-1:0]  out_theta
);
	import gmm_pkg::*;

	localparam int REM_W = TH_W + 2;

	logic [TH_W:1]     vld_s;
	side_t             side_s [1:TH_W];
	logic [RAD_PW-1:0] rad_s  [1:TH_W];
	logic [REM_W-1:0]  rem_s  [1:TH_W];
	logic [TH_W-1:0]   root_s [1:TH_W];

	// valid bits travel one stage per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[TH_W-1:1], in_valid};
		end
	end

	// one result bit per stage, radicand consumed two bits at a time
	for (genvar i = 0; i < TH_W; i++) begin : g_step
		side_t             side_in;
		logic [RAD_PW-1:0] rad_in;
		logic [REM_W-1:0]  rem_in;
		logic [TH_W-1:0]   root_in;
		logic [REM_W-1:0]  rem_sh;
		logic [REM_W-1:0]  trial;
		logic              ge;

		if (i == 0) begin : g_first
			assign side_in = in_side;
			assign rad_in  = RAD_PW'({in_side.ts, {FRAC_BITS{1'b0}}});
			assign rem_in  = '0;
			assign root_in = '0;
		end else begin : g_next
			assign side_in = side_s[i];
			assign rad_in  = rad_s[i];
			assign rem_in  = rem_s[i];
			assign root_in = root_s[i];
		end

		assign rem_sh = {rem_in[REM_W-3:0], rad_in[RAD_PW-1 -: 2]};
		assign trial  = {root_in, 2'b01};
		assign ge     = (rem_sh >= trial);

		always_ff @(posedge clk) begin
			side_s[i+1] <= side_in;
			rad_s[i+1]  <= rad_in << 2;
			rem_s[i+1]  <= ge ? (rem_sh - trial) : rem_sh;
			root_s[i+1] <= {root_in[TH_W-2:0], ge};
		end
	end

	assign out_valid = vld_s[TH_W];
	assign out_side  = side_s[TH_W];
	assign out_theta = root_s[TH_W];

endmodule

>>> rtl/core/gmm_div.sv
module gmm_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  gmm_pkg::side_t            in_side,
	input  logic [gmm_pkg::TH_W-1:0]  in_theta,
	output logic                      out_valid,
	output gmm_pkg::side_t            out_side,
	output logic [gmm_pkg::TH_W-1:0]  out_theta,
	output logic [gmm_pkg::Q_W-1:0]   out_amag,
	output logic                      out_ovf
);
	import gmm_pkg::*;

	localparam int NUM_W = DM_W + FRAC_BITS;
	localparam int HI_W  = NUM_W - Q_W;
	localparam int CMP_W = (HI_W > TH_W) ? HI_W : TH_W;
	localparam int NST   = Q_W + 1;

	logic [NST:1]     vld_s;
	side_t            side_s  [1:NST];
	logic [TH_W-1:0]  theta_s [1:NST];
	logic [TH_W-1:0]  rem_s   [1:NST];
	logic [Q_W-1:0]   low_s   [1:NST];
	logic [Q_W-1:0]   quo_s   [1:NST];
	logic             ovf_s   [1:NST];

	logic [NUM_W-1:0] num;
	logic [HI_W-1:0]  num_hi;
	logic             ovf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[NST-1:1], in_valid};
		end
	end

	// quotient overflow check: anything at or past 2^Q_W saturates alpha
	assign num    = {in_side.dmag, {FRAC_BITS{1'b0}}};
	assign num_hi = num[NUM_W-1:Q_W];
	assign ovf    = (CMP_W'(num_hi) >= CMP_W'(in_theta));

	always_ff @(posedge clk) begin
		side_s[1]  <= in_side;
		theta_s[1] <= in_theta;
		rem_s[1]   <= TH_W'(num_hi);
		low_s[1]   <= num[Q_W-1:0];
		quo_s[1]   <= '0;
		ovf_s[1]   <= ovf;
	end

	// restoring division, one quotient bit per stage
	for (genvar k = 1; k < NST; k++) begin : g_step
		logic [TH_W:0] rsh;
		logic          ge;

		assign rsh = {rem_s[k], low_s[k][Q_W-1]};
		assign ge  = (rsh >= {1'b0, theta_s[k]});

		always_ff @(posedge clk) begin
			side_s[k+1]  <= side_s[k];
			theta_s[k+1] <= theta_s[k];
			rem_s[k+1]   <= ge ? TH_W'(rsh - {1'b0, theta_s[k]}) : TH_W'(rsh);
			low_s[k+1]   <= low_s[k] << 1;
			quo_s[k+1]   <= {quo_s[k][Q_W-2:0], ge};
			ovf_s[k+1]   <= ovf_s[k];
		end
	end

	assign out_valid = vld_s[NST];
	assign out_side  = side_s[NST];
	assign out_theta = theta_s[NST];
	assign out_amag  = quo_s[NST];
	assign out_ovf   = ovf_s[NST];

endmodule
